[src/pmlp_pkg.sv]
// Package: types, constants and the hash multiplier for the page map probe table.
`default_nettype none
package pmlp_pkg;
   localparam int unsigned CAPACITY  = 1024;
   localparam int unsigned SLOT_W    = $clog2(CAPACITY);
   localparam int unsigned COUNT_W   = SLOT_W + 1;
   localparam int unsigned LIMIT_NUM = CAPACITY * 7;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ZERO   = 2'd3;

   localparam logic [63:0] MIX_MULT = 64'h2545F4914F6CDD1D;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] page_number;
      logic [31:0] owner_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] owner_found;
      logic [10:0] occupancy;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_HASH_A, S_HASH_B, S_HASH_C, S_READ, S_CHECK,
      S_MV_READ, S_MV_CHECK, S_MV_HASH_A, S_MV_HASH_B, S_MV_HASH_C,
      S_MV_READ2, S_MV_CHECK2, S_RESP
   } state_type;
endpackage
`default_nettype wire

[src/page_map_linear_probe_table_unit.sv]
// Top level: page map hash table with linear probing over key and owner RAMs.
`default_nettype none
// One item at a time. After reset a clearing pass zeros the key and owner RAMs,
// one slot a cycle, during which no item is taken. An item passes an accept
// state, the hashing states, a read and a check per probed slot on the single
// RAM port and a response state; a zero key or the ACT_NONE action skips hashing
// and probing. A remove that finds its key then walks the run after the cleared
// slot, reading, rehashing and rereading each entry, and empties the last hole
// at the empty slot that ends the run. The response sits in an output register;
// a stalled response holds the unit, next response ready, in its response state.
module page_map_linear_probe_table_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pmlp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pmlp_pkg::rsp_type      rsp_data
);
   localparam int unsigned SW = pmlp_pkg::SLOT_W;
   localparam int unsigned CW = pmlp_pkg::COUNT_W;

   pmlp_pkg::state_type state_ff, state_in;
   pmlp_pkg::req_type   req_ff, req_in;
   pmlp_pkg::rsp_type   rsp_ff, rsp_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] hole_ff, hole_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [31:0]   mkey_ff, mkey_in;
   logic [31:0]   mown_ff, mown_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [SW-1:0] addr;
   logic [31:0]   key_wr, own_wr, key_rd, own_rd;
   logic [1:0]    hphase;
   logic [31:0]   hkey;
   logic [SW-1:0] home;
   logic          full;

   pmlp_ram #(.WIDTH(32), .DEPTH(pmlp_pkg::CAPACITY)) u_keys (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(key_wr), .rd_data(key_rd));
   pmlp_ram #(.WIDTH(32), .DEPTH(pmlp_pkg::CAPACITY)) u_owners (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(own_wr), .rd_data(own_rd));
   pmlp_hash u_hash (.clock(clock), .phase(hphase), .key(hkey), .home(home));

   assign full = ((32'(count_ff) + 32'd1) * 32'd10) > 32'(pmlp_pkg::LIMIT_NUM);

   // between hole and scan (circular), excluding hole: home in (hole, scan]
   function automatic logic stays(input logic [SW-1:0] h, input logic [SW-1:0] hole,
                                  input logic [SW-1:0] scan);
      logic [SW-1:0] dh, ds;
      dh = h - hole;
      ds = scan - hole;
      return (dh != '0) && (dh <= ds);
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmlp_pkg::S_CLEAR:
            if (clr_ff == SW'(pmlp_pkg::CAPACITY - 1)) state_in = pmlp_pkg::S_IDLE;
         pmlp_pkg::S_IDLE:
            if (req_valid) begin
               state_in = (req_data.page_number == 32'd0 ||
                           req_data.action == pmlp_pkg::ACT_NONE)
                          ? pmlp_pkg::S_RESP : pmlp_pkg::S_HASH_A;
            end
         pmlp_pkg::S_HASH_A: state_in = pmlp_pkg::S_HASH_B;
         pmlp_pkg::S_HASH_B: state_in = pmlp_pkg::S_HASH_C;
         pmlp_pkg::S_HASH_C: state_in = pmlp_pkg::S_READ;
         pmlp_pkg::S_READ:   state_in = pmlp_pkg::S_CHECK;
         pmlp_pkg::S_CHECK:
            if (key_rd != 32'd0 && key_rd != req_ff.page_number) state_in = pmlp_pkg::S_READ;
            else if (req_ff.action == pmlp_pkg::ACT_REMOVE && key_rd != 32'd0)
               state_in = pmlp_pkg::S_MV_READ;
            else state_in = pmlp_pkg::S_RESP;
         pmlp_pkg::S_MV_READ: state_in = pmlp_pkg::S_MV_CHECK;
         pmlp_pkg::S_MV_CHECK:
            state_in = (key_rd == 32'd0) ? pmlp_pkg::S_RESP : pmlp_pkg::S_MV_HASH_A;
         pmlp_pkg::S_MV_HASH_A: state_in = pmlp_pkg::S_MV_HASH_B;
         pmlp_pkg::S_MV_HASH_B: state_in = pmlp_pkg::S_MV_HASH_C;
         pmlp_pkg::S_MV_HASH_C: state_in = pmlp_pkg::S_MV_READ2;
         pmlp_pkg::S_MV_READ2:  state_in = pmlp_pkg::S_MV_CHECK2;
         pmlp_pkg::S_MV_CHECK2: state_in = pmlp_pkg::S_MV_READ;
         pmlp_pkg::S_RESP:
            if (!rsp_valid_ff || !rsp_stall) state_in = pmlp_pkg::S_IDLE;
         default: state_in = pmlp_pkg::S_IDLE;
      endcase
   end

   // Remove uses backward-shift: entry at scan moves into hole unless its home
   // lies cyclically in (hole, scan]; equals the model's reinsert result.
   always_comb begin
      req_in = req_ff; slot_in = slot_ff; hole_in = hole_ff; scan_in = scan_ff;
      count_in = count_ff; clr_in = clr_ff; mkey_in = mkey_ff; mown_in = mown_ff;
      status_in = status_ff; found_in = found_ff; rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0; addr = slot_ff; key_wr = 32'd0; own_wr = 32'd0;
      hphase = 2'd3; hkey = req_ff.page_number;
      req_stall = (state_ff != pmlp_pkg::S_IDLE);
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         pmlp_pkg::S_CLEAR: begin
            wr_en = 1'b1; addr = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         pmlp_pkg::S_IDLE:
            if (req_valid) begin
               req_in = req_data; found_in = 32'd0;
               status_in = (req_data.page_number == 32'd0) ? pmlp_pkg::ST_ZERO
                                                          : pmlp_pkg::ST_ABSENT;
            end
         pmlp_pkg::S_HASH_A: hphase = 2'd0;
         pmlp_pkg::S_HASH_B: hphase = 2'd1;
         pmlp_pkg::S_HASH_C: begin hphase = 2'd2; end
         pmlp_pkg::S_READ: begin
            addr = slot_ff;
         end
         pmlp_pkg::S_CHECK: begin
            if (key_rd != 32'd0 && key_rd != req_ff.page_number) begin
               slot_in = slot_ff + 1'b1;
            end else if (key_rd == req_ff.page_number) begin
               status_in = pmlp_pkg::ST_DONE;
               case (req_ff.action)
                  pmlp_pkg::ACT_LOOKUP: found_in = own_rd;
                  pmlp_pkg::ACT_INSERT: begin
                     wr_en = 1'b1; key_wr = key_rd; own_wr = req_ff.owner_handle;
                  end
                  pmlp_pkg::ACT_REMOVE: begin
                     wr_en = 1'b1; count_in = count_ff - 1'b1;
                     hole_in = slot_ff; scan_in = slot_ff + 1'b1;
                  end
                  default: ;
               endcase
            end else if (req_ff.action == pmlp_pkg::ACT_INSERT) begin
               if (full) status_in = pmlp_pkg::ST_FULL;
               else begin
                  status_in = pmlp_pkg::ST_DONE; wr_en = 1'b1;
                  key_wr = req_ff.page_number; own_wr = req_ff.owner_handle;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         pmlp_pkg::S_MV_READ: addr = scan_ff;
         pmlp_pkg::S_MV_CHECK: begin
            mkey_in = key_rd; mown_in = own_rd;
            if (key_rd == 32'd0) begin
               // run ended: empty the last hole
               addr = hole_ff; wr_en = 1'b1;
            end else begin
               addr = scan_ff;
            end
         end
         pmlp_pkg::S_MV_HASH_A: begin hphase = 2'd0; hkey = mkey_ff; end
         pmlp_pkg::S_MV_HASH_B: begin hphase = 2'd1; hkey = mkey_ff; end
         pmlp_pkg::S_MV_HASH_C: begin hphase = 2'd2; hkey = mkey_ff; end
         pmlp_pkg::S_MV_READ2: addr = scan_ff;
         pmlp_pkg::S_MV_CHECK2: begin
            if (!stays(home, hole_ff, scan_ff)) begin
               addr = hole_ff; wr_en = 1'b1; key_wr = mkey_ff; own_wr = mown_ff;
               hole_in = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
         end
         pmlp_pkg::S_RESP:
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: status_ff, owner_found: found_ff,
                          occupancy: 11'(count_ff)};
            end
         default: ;
      endcase
      if (state_ff == pmlp_pkg::S_HASH_C) slot_in = slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmlp_pkg::S_CLEAR; clr_ff <= '0; count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in; hole_ff <= hole_in; scan_ff <= scan_in;
      mkey_ff <= mkey_in; mown_ff <= mown_in; status_ff <= status_in; found_ff <= found_in;
      rsp_ff <= rsp_in;
      slot_ff <= (state_ff == pmlp_pkg::S_HASH_C) ? home : slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pmlp_pkg::S_IDLE) |-> req_stall)
      else $error("item taken while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) * 32'd10) <= 32'(pmlp_pkg::LIMIT_NUM))
      else $error("occupancy past load limit");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("stalled response changed");
`endif
endmodule
`default_nettype wire

[src/pmlp_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module pmlp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[src/pmlp_hash.sv]
// Xorshift-multiply hash with 32x32 partial products accumulated over phases.
`default_nettype none
module pmlp_hash (
   input  wire logic                        clock,
   input  wire logic [1:0]                  phase,
   input  wire logic [31:0]                 key,
   output logic      [pmlp_pkg::SLOT_W-1:0] home
);
   logic [31:0] v;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mixed;

   assign v = key ^ (key >> 15);

   always_comb begin
      acc_in = acc_ff;
      case (phase)
         2'd0: begin
            acc_in = v * pmlp_pkg::MIX_MULT[31:0];
         end
         2'd1: begin
            acc_in = acc_ff + {(v * pmlp_pkg::MIX_MULT[63:32]), 32'd0};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign mixed = acc_ff ^ (acc_ff >> 21);
   assign home  = mixed[pmlp_pkg::SLOT_W-1:0];
endmodule
`default_nettype wire

[sim/page_map_linear_probe_table_unit_tb.sv]
// Testbench for the page map probe table: queued driver, clocked monitor, table predictor.
`default_nettype none
module page_map_linear_probe_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOT_MASK   = pmlp_pkg::CAPACITY - 1;
   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned HOLD_CYCLES = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pmlp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pmlp_pkg::rsp_type rsp_data;

   page_map_linear_probe_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [31:0] key_mirror [pmlp_pkg::CAPACITY];
   logic [31:0] owner_mirror [pmlp_pkg::CAPACITY];
   int unsigned occupied_mirror;

   pmlp_pkg::req_type pending_reqs [$];
   pmlp_pkg::rsp_type expected_rsps [$];
   logic [31:0]       live_keys [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;

   function automatic int unsigned home_slot(input logic [31:0] page);
      logic [63:0] v;
      v = {32'd0, page};
      v = v ^ (v >> 15);
      v = v * pmlp_pkg::MIX_MULT;
      v = v ^ (v >> 21);
      return int'(v[pmlp_pkg::SLOT_W-1:0]);
   endfunction

   function automatic int unsigned probe_slot(input logic [31:0] page);
      int unsigned slot;
      slot = home_slot(page);
      for (int unsigned n = 0; n < pmlp_pkg::CAPACITY; n++) begin
         if (key_mirror[slot] == 0 || key_mirror[slot] == page) return slot;
         slot = (slot + 1) & SLOT_MASK;
      end
      return slot;
   endfunction

   function automatic void place_entry(input logic [31:0] page, input logic [31:0] owner);
      int unsigned slot;
      slot = probe_slot(page);
      if (key_mirror[slot] == 0) occupied_mirror++;
      key_mirror[slot] = page;
      owner_mirror[slot] = owner;
   endfunction

   function automatic pmlp_pkg::rsp_type predict_table(input pmlp_pkg::req_type r);
      pmlp_pkg::rsp_type o;
      int unsigned slot;
      int unsigned nxt;
      logic [31:0] k;
      logic [31:0] w;
      o.status = pmlp_pkg::ST_ABSENT;
      o.owner_found = '0;
      if (r.page_number == 0) begin
         o.status = pmlp_pkg::ST_ZERO;
      end else if (r.action == pmlp_pkg::ACT_LOOKUP) begin
         slot = probe_slot(r.page_number);
         if (key_mirror[slot] == r.page_number) begin
            o.status = pmlp_pkg::ST_DONE;
            o.owner_found = owner_mirror[slot];
         end
      end else if (r.action == pmlp_pkg::ACT_INSERT) begin
         slot = probe_slot(r.page_number);
         if (key_mirror[slot] == r.page_number) begin
            owner_mirror[slot] = r.owner_handle;
            o.status = pmlp_pkg::ST_DONE;
         end else if ((occupied_mirror + 1) * 10 > pmlp_pkg::LIMIT_NUM) begin
            o.status = pmlp_pkg::ST_FULL;
         end else begin
            place_entry(r.page_number, r.owner_handle);
            o.status = pmlp_pkg::ST_DONE;
         end
      end else if (r.action == pmlp_pkg::ACT_REMOVE) begin
         slot = probe_slot(r.page_number);
         if (key_mirror[slot] == r.page_number) begin
            key_mirror[slot] = 0;
            occupied_mirror--;
            nxt = (slot + 1) & SLOT_MASK;
            for (int unsigned n = 0; n < pmlp_pkg::CAPACITY && key_mirror[nxt] != 0; n++)
            begin
               k = key_mirror[nxt];
               w = owner_mirror[nxt];
               key_mirror[nxt] = 0;
               occupied_mirror--;
               place_entry(k, w);
               nxt = (nxt + 1) & SLOT_MASK;
            end
            o.status = pmlp_pkg::ST_DONE;
         end
      end
      o.occupancy = occupied_mirror[10:0];
      return o;
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [31:0] pick_key(input bit fresh);
      if (!fresh && live_keys.size() > 0 && $urandom_range(0, 3) != 0)
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      if ($urandom_range(0, 1) == 0) return $urandom_range(1, 4000);
      return $urandom() | 32'd1 << $urandom_range(0, 31);
   endfunction

   task automatic queue_req(input logic [1:0] act, input logic [31:0] page,
                            input logic [31:0] owner);
      pmlp_pkg::req_type r;
      r.action = act;
      r.page_number = page;
      r.owner_handle = owner;
      pending_reqs.push_back(r);
      if (act == pmlp_pkg::ACT_INSERT && page != 0) live_keys.push_back(page);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         expected_rsps.push_back(predict_table(req_data));
         send_gap = pick_gap();
         if (send_gap == 0 && pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pmlp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_data), 64'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.owner_found !== want.owner_found)
                  report_mismatch("owner_found", 64'(rsp_data.owner_found),
                                  64'(want.owner_found));
               if (rsp_data.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 64'(rsp_data.occupancy),
                                  64'(want.occupancy));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int unsigned burst;
      logic [31:0] k;
      for (int i = 0; i < pmlp_pkg::CAPACITY; i++) begin
         key_mirror[i] = '0;
         owner_mirror[i] = '0;
      end
      occupied_mirror = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_req(pmlp_pkg::ACT_LOOKUP, 32'd5, 32'd0);
      queue_req(pmlp_pkg::ACT_REMOVE, 32'd5, 32'd0);
      queue_req(pmlp_pkg::ACT_INSERT, 32'd0, 32'hFFFF_FFFF);
      queue_req(pmlp_pkg::ACT_LOOKUP, 32'd0, 32'd0);
      queue_req(pmlp_pkg::ACT_REMOVE, 32'd0, 32'd0);
      queue_req(pmlp_pkg::ACT_INSERT, 32'd1, 32'hFFFF_FFFF);
      queue_req(pmlp_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'd0);
      queue_req(pmlp_pkg::ACT_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
      queue_req(pmlp_pkg::ACT_LOOKUP, 32'd1, 32'd0);
      queue_req(pmlp_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd7);
      queue_req(pmlp_pkg::ACT_INSERT, 32'd1, 32'h1234_5678);
      queue_req(pmlp_pkg::ACT_LOOKUP, 32'd1, 32'd0);
      queue_req(pmlp_pkg::ACT_NONE, 32'd1, 32'd9);
      queue_req(pmlp_pkg::ACT_NONE, 32'd0, 32'd9);
      queue_req(pmlp_pkg::ACT_REMOVE, 32'd1, 32'd0);
      queue_req(pmlp_pkg::ACT_LOOKUP, 32'd1, 32'd0);
      queue_req(pmlp_pkg::ACT_LOOKUP, 32'h8000_0000, 32'd0);
      queue_req(pmlp_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'd0);
      queue_req(pmlp_pkg::ACT_REMOVE, 32'h8000_0000, 32'd0);

      for (int i = 0; i < 300; i++) begin
         if (i == 200) begin
            wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
         end
         if (i == 60) begin
            // build long runs, then remove random live keys to shift them, each followed by a lookup
            for (int j = 0; j < 80; j++) queue_req(pmlp_pkg::ACT_INSERT,
                                                   $urandom_range(1, 20000), $urandom());
            for (int j = 0; j < 25; j++) begin
               k = live_keys[$urandom_range(0, live_keys.size() - 1)];
               queue_req(pmlp_pkg::ACT_REMOVE, k, $urandom());
               queue_req(pmlp_pkg::ACT_LOOKUP,
                         live_keys[$urandom_range(0, live_keys.size() - 1)], 32'd0);
            end
         end
         burst = $urandom_range(0, 19);
         if (burst < 8) queue_req(pmlp_pkg::ACT_INSERT, pick_key(burst < 4), $urandom());
         else if (burst < 13) queue_req(pmlp_pkg::ACT_LOOKUP, pick_key(1'b0), $urandom());
         else if (burst < 18) queue_req(pmlp_pkg::ACT_REMOVE, pick_key(1'b0), $urandom());
         else if (burst == 18) queue_req(pmlp_pkg::ACT_NONE, pick_key(1'b0), $urandom());
         else queue_req(2'($urandom_range(0, 3)), 32'd0, $urandom());
         if (pending_reqs.size() > 50)
            wait (pending_reqs.size() < 10);
      end
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (HOLD_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
